// File: sv/ttw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Text terminal writer package
// Shared character codes, reset values, item kinds and queue word types.
// ----------------------------------------------------------------------------
package ttw_pkg;

   localparam int DEF_COLUMNS      = 80;
   localparam int DEF_ROWS         = 25;
   localparam int DEF_ESCAPE_LIMIT = 15;

   localparam logic [7:0] CH_BELL     = 8'd7;
   localparam logic [7:0] CH_BS       = 8'd8;
   localparam logic [7:0] CH_NL       = 8'd10;
   localparam logic [7:0] CH_ESC      = 8'd27;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] CH_SEMI     = 8'h3B;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_H        = 8'h48;
   localparam logic [7:0] CH_J        = 8'h4A;
   localparam logic [7:0] CH_K        = 8'h4B;
   localparam logic [7:0] CH_FINAL_LO = 8'd64;
   localparam logic [7:0] CH_FINAL_HI = 8'd127;

   localparam logic [7:0]  ATTR_RESET = 8'd7;
   localparam logic [15:0] CELL_RESET = 16'h0720;
   localparam logic [9:0]  PARAM_MAX  = 10'd999;

   localparam int ALT_SEQ_LEN = 8;
   localparam logic [7:0] SEQ_ALT_ON [ALT_SEQ_LEN] =
      '{8'd27, 8'h5B, 8'h3F, 8'h31, 8'h30, 8'h34, 8'h39, 8'h68};
   localparam logic [7:0] SEQ_ALT_OFF [ALT_SEQ_LEN] =
      '{8'd27, 8'h5B, 8'h3F, 8'h31, 8'h30, 8'h34, 8'h39, 8'h6C};

   typedef enum logic [2:0] {
      KIND_READ,
      KIND_BELL,
      KIND_ESC_START,
      KIND_ESC_BYTE,
      KIND_ESC_FINAL,
      KIND_BS,
      KIND_NL,
      KIND_PRINT
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [10:0] read_index;
      logic        read_screen;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

endpackage
`default_nettype wire

// File: sv/ttw_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Text terminal writer channels
// Request, response and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface ttw_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [7:0]  data_byte;
   logic [10:0] read_index;
   logic        read_screen;
   modport source(output valid, cmd, data_byte, read_index, read_screen, input ready);
   modport sink(input valid, cmd, data_byte, read_index, read_screen, output ready);
endinterface

interface ttw_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] cell_value;
   logic [10:0] cursor_pos;
   logic        alt_active;
   logic        beep;
   logic        escape_pending;
   modport source(output valid, cell_value, cursor_pos, alt_active, beep, escape_pending,
                  input ready);
   modport sink(input valid, cell_value, cursor_pos, alt_active, beep, escape_pending,
                output ready);
endinterface

interface ttw_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_attribute;
   modport source(output valid, text_attribute, input ready);
   modport sink(input valid, text_attribute, output ready);
endinterface
`default_nettype wire

// File: sv/text_terminal_writer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Text terminal writer
// Simple words (print, bell, backspace, newline, read, escape byte): direct.
// Newline or print past the last cell: scroll up one row, blank the last row.
// Escape final byte: parse the held escape bytes, then apply the sequence;
// J, K and ?1049h then blank their cells.
// After reset a clearing pass of 2*ROWS*COLUMNS cells (4000) holds off input.
// ----------------------------------------------------------------------------
module text_terminal_writer_top import ttw_pkg::*; #(
   parameter int COLUMNS      = DEF_COLUMNS,
   parameter int ROWS         = DEF_ROWS,
   parameter int ESCAPE_LIMIT = DEF_ESCAPE_LIMIT
) (
   input  logic      clock,
   input  logic      reset,
   ttw_req_if.sink   req_ch,
   ttw_rsp_if.source rsp_ch,
   ttw_csr_if.sink   csr_ch
);
   head_type head;
   logic     pop;
   logic     clear_busy;

   ttw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .clear_busy (clear_busy),
      .pop        (pop),
      .head       (head)
   );

   ttw_back #(
      .COLUMNS      (COLUMNS),
      .ROWS         (ROWS),
      .ESCAPE_LIMIT (ESCAPE_LIMIT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_ch     (csr_ch),
      .rsp_ch     (rsp_ch),
      .head       (head),
      .pop        (pop),
      .clear_busy (clear_busy)
   );
endmodule
`default_nettype wire

// File: sv/ttw_cell_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Cell store
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ttw_cell_ram #(
   parameter int DEPTH = 4000,
   parameter int AW    = 12
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [15:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [15:0]   rd_data
);
   logic [15:0] mem [DEPTH];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// File: sv/ttw_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Text terminal writer front
// Accept request words, classify them, and queue them for the back end.
// ----------------------------------------------------------------------------
module ttw_front import ttw_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   ttw_req_if.sink  req_ch,
   input  logic     clear_busy,
   input  logic     pop,
   output head_type head
);
   logic        in_esc_ff, in_esc_in;
   item_type    q_ff [2];
   logic        wp_ff, rp_ff;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push, do_pop;
   item_type    item;
   logic [7:0]  b;

   assign b            = req_ch.data_byte;
   assign req_ch.ready = (cnt_ff != 2'd2) && !clear_busy;
   assign push         = req_ch.valid && req_ch.ready;
   assign do_pop       = pop && (cnt_ff != 2'd0);

   always_comb begin
      item.data_byte   = b;
      item.read_index  = req_ch.read_index;
      item.read_screen = req_ch.read_screen;
      item.kind        = KIND_PRINT;
      in_esc_in        = in_esc_ff;
      if (req_ch.cmd) begin
         item.kind = KIND_READ;
      end else if (in_esc_ff) begin
         if (b >= CH_FINAL_LO && b <= CH_FINAL_HI && b != CH_LBRACKET) begin
            item.kind = KIND_ESC_FINAL;
            in_esc_in = 1'b0;
         end else begin
            item.kind = KIND_ESC_BYTE;
         end
      end else begin
         unique case (b)
            CH_BELL: item.kind = KIND_BELL;
            CH_ESC: begin
               item.kind = KIND_ESC_START;
               in_esc_in = 1'b1;
            end
            CH_BS:   item.kind = KIND_BS;
            CH_NL:   item.kind = KIND_NL;
            default: item.kind = KIND_PRINT;
         endcase
      end
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_esc_ff <= 1'b0;
         wp_ff     <= 1'b0;
         rp_ff     <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            in_esc_ff <= in_esc_in;
            wp_ff     <= !wp_ff;
         end
         if (do_pop) begin
            rp_ff <= !rp_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= item;
      end
   end

   assign head.valid = (cnt_ff != 2'd0);
   assign head.item  = q_ff[rp_ff];
endmodule
`default_nettype wire

// File: sv/ttw_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Text terminal writer back end
// Execute queued words on the cell store: writes, scroll, erase, escapes.
// ----------------------------------------------------------------------------
module ttw_back import ttw_pkg::*; #(
   parameter int COLUMNS      = DEF_COLUMNS,
   parameter int ROWS         = DEF_ROWS,
   parameter int ESCAPE_LIMIT = DEF_ESCAPE_LIMIT
) (
   input  logic      clock,
   input  logic      reset,
   ttw_csr_if.sink   csr_ch,
   ttw_rsp_if.source rsp_ch,
   input  head_type  head,
   output logic      pop,
   output logic      clear_busy
);
   localparam int CELLS  = COLUMNS * ROWS;
   localparam int CUR_W  = $clog2(CELLS + 1);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int MEM_D  = 2 * CELLS;
   localparam int MEM_AW = $clog2(MEM_D);
   localparam int CNT_W  = $clog2(ESCAPE_LIMIT + 1);
   localparam int SIDX_W = $clog2(ESCAPE_LIMIT);

   localparam logic [CUR_W-1:0] CELLS_C    = CUR_W'(CELLS);
   localparam logic [CUR_W-1:0] COLS_C     = CUR_W'(COLUMNS);
   localparam logic [CUR_W-1:0] LAST_ROW_C = CUR_W'(CELLS - COLUMNS);
   localparam logic [COL_W-1:0] COL_MAX    = COL_W'(COLUMNS - 1);
   localparam logic [9:0]       ROWS_P     = 10'(ROWS);
   localparam logic [9:0]       COLS_P     = 10'(COLUMNS);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_DONE   = 3'd2;
   localparam logic [2:0] S_SCROLL = 3'd3;
   localparam logic [2:0] S_FILL   = 3'd4;
   localparam logic [2:0] S_PARSE  = 3'd5;
   localparam logic [2:0] S_APPLY  = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [7:0]        attr_ff;
   logic              alt_ff, alt_in;
   logic [CUR_W-1:0]  cur_main_ff, cur_alt_ff;
   logic [COL_W-1:0]  col_main_ff, col_alt_ff;
   logic [CNT_W-1:0]  esc_cnt_ff, esc_cnt_in;
   logic [7:0]        esc_store_ff [ESCAPE_LIMIT];
   logic [7:0]        final_byte_ff, final_byte_in;
   logic [CNT_W-1:0]  walk_ff, walk_in;
   logic [9:0]        row_num_ff, row_num_in, col_num_ff, col_num_in;
   logic              row_act_ff, row_act_in, col_act_ff, col_act_in, semi_ff, semi_in;
   logic              beep_ff, beep_in, cell_sel_ff, cell_sel_in;
   logic [MEM_AW-1:0] clr_ptr_ff, clr_ptr_in;
   logic [CUR_W-1:0]  ptr_ff, ptr_in, end_ff, end_in, pw_idx_ff, pw_idx_in;
   logic              pw_valid_ff, pw_valid_in, wscr_ff, wscr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       rsp_cell_ff, rsp_cell_in;
   logic [10:0]       rsp_cur_ff, rsp_cur_in;
   logic              rsp_alt_ff, rsp_alt_in, rsp_beep_ff, rsp_beep_in, rsp_esc_ff, rsp_esc_in;

   logic              acur_we;
   logic [CUR_W-1:0]  acur_new, cur_act;
   logic [COL_W-1:0]  acol_new, col_act;
   logic              st_we;
   logic [SIDX_W-1:0] st_idx;
   logic              mem_we, mem_re;
   logic [MEM_AW-1:0] mem_waddr, mem_raddr;
   logic [15:0]       mem_wdata, mem_rdata;
   logic [7:0]        walk_b, hb;
   logic              alt_on_hit, alt_off_hit;
   logic [9:0]        row_c, col_c, col_m1;
   logic [19:0]       h_prod;
   logic [CUR_W:0]    nl_sum;
   logic [CUR_W-1:0]  pr_cur, k_start;

   function automatic logic [MEM_AW-1:0] cell_addr(input logic scr,
                                                   input logic [CUR_W-1:0] idx);
      logic [MEM_AW-1:0] base;
      base = scr ? MEM_AW'(CELLS) : '0;
      return base + MEM_AW'(idx);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic [9:0] dec_step(input logic [9:0] v, input logic [7:0] c);
      logic [13:0] s;
      s = 14'(v) * 14'd10 + 14'(c - CH_ZERO);
      return (s > 14'(PARAM_MAX)) ? PARAM_MAX : s[9:0];
   endfunction

   ttw_cell_ram #(.DEPTH(MEM_D), .AW(MEM_AW)) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign csr_ch.ready = 1'b1;
   assign clear_busy   = (state_ff == S_CLEAR);
   assign cur_act      = alt_ff ? cur_alt_ff : cur_main_ff;
   assign col_act      = alt_ff ? col_alt_ff : col_main_ff;
   assign walk_b       = esc_store_ff[walk_ff[SIDX_W-1:0]];
   assign hb           = head.item.data_byte;

   always_comb begin
      alt_on_hit  = (esc_cnt_ff == CNT_W'(ALT_SEQ_LEN));
      alt_off_hit = alt_on_hit;
      for (int k = 0; k < ALT_SEQ_LEN; k++) begin
         if (esc_store_ff[k] != SEQ_ALT_ON[k]) alt_on_hit = 1'b0;
         if (esc_store_ff[k] != SEQ_ALT_OFF[k]) alt_off_hit = 1'b0;
      end
      row_c  = (row_num_ff == 10'd0) ? 10'd1 : ((row_num_ff > ROWS_P) ? ROWS_P : row_num_ff);
      col_c  = (col_num_ff == 10'd0) ? 10'd1 : ((col_num_ff > COLS_P) ? COLS_P : col_num_ff);
      col_m1 = col_c - 10'd1;
      h_prod = 20'(row_c - 10'd1) * 20'(COLUMNS) + 20'(col_m1);
      nl_sum = {1'b0, cur_act} + (CUR_W+1)'(COLUMNS) - (CUR_W+1)'(col_act);
      pr_cur = cur_act + 1'b1;
      k_start = cur_act - CUR_W'(col_act);
   end

   always_comb begin
      state_in      = state_ff;
      alt_in        = alt_ff;
      esc_cnt_in    = esc_cnt_ff;
      final_byte_in = final_byte_ff;
      walk_in       = walk_ff;
      row_num_in    = row_num_ff;
      col_num_in    = col_num_ff;
      row_act_in    = row_act_ff;
      col_act_in    = col_act_ff;
      semi_in       = semi_ff;
      beep_in       = beep_ff;
      cell_sel_in   = cell_sel_ff;
      clr_ptr_in    = clr_ptr_ff;
      ptr_in        = ptr_ff;
      end_in        = end_ff;
      pw_idx_in     = pw_idx_ff;
      pw_valid_in   = 1'b0;
      wscr_in       = wscr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_cell_in   = rsp_cell_ff;
      rsp_cur_in    = rsp_cur_ff;
      rsp_alt_in    = rsp_alt_ff;
      rsp_beep_in   = rsp_beep_ff;
      rsp_esc_in    = rsp_esc_ff;
      acur_we       = 1'b0;
      acur_new      = cur_act;
      acol_new      = col_act;
      st_we         = 1'b0;
      st_idx        = esc_cnt_ff[SIDX_W-1:0];
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = {attr_ff, CH_SPACE};
      mem_re        = 1'b0;
      mem_raddr     = '0;
      pop           = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ptr_ff;
            mem_wdata = CELL_RESET;
            if (clr_ptr_ff == MEM_AW'(MEM_D - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_ptr_in = clr_ptr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (head.valid) begin
               pop         = 1'b1;
               beep_in     = 1'b0;
               cell_sel_in = 1'b0;
               state_in    = S_DONE;
               unique case (head.item.kind) inside
                  KIND_READ: begin
                     if (16'(head.item.read_index) < 16'(CELLS)) begin
                        mem_re      = 1'b1;
                        mem_raddr   = cell_addr(head.item.read_screen,
                                                CUR_W'(head.item.read_index));
                        cell_sel_in = 1'b1;
                     end
                  end
                  KIND_BELL: beep_in = 1'b1;
                  KIND_ESC_START: begin
                     st_we      = 1'b1;
                     st_idx     = '0;
                     esc_cnt_in = CNT_W'(1);
                  end
                  KIND_ESC_BYTE, KIND_ESC_FINAL: begin
                     if (esc_cnt_ff < CNT_W'(ESCAPE_LIMIT)) begin
                        st_we      = 1'b1;
                        esc_cnt_in = esc_cnt_ff + 1'b1;
                     end
                     if (head.item.kind == KIND_ESC_FINAL) begin
                        final_byte_in = hb;
                        walk_in       = '0;
                        row_num_in    = 10'd0;
                        col_num_in    = 10'd1;
                        row_act_in    = 1'b1;
                        col_act_in    = 1'b0;
                        semi_in       = 1'b0;
                        state_in      = S_PARSE;
                     end
                  end
                  KIND_BS: begin
                     if (cur_act != '0) begin
                        acur_we   = 1'b1;
                        acur_new  = cur_act - 1'b1;
                        acol_new  = (col_act == '0) ? COL_MAX : col_act - 1'b1;
                        mem_we    = 1'b1;
                        mem_waddr = cell_addr(alt_ff, cur_act - 1'b1);
                     end
                  end
                  KIND_NL: begin
                     acur_we  = 1'b1;
                     acol_new = '0;
                     if (nl_sum >= (CUR_W+1)'(CELLS)) begin
                        acur_new = LAST_ROW_C;
                        wscr_in  = alt_ff;
                        ptr_in   = COLS_C;
                        state_in = S_SCROLL;
                     end else begin
                        acur_new = nl_sum[CUR_W-1:0];
                     end
                  end
                  KIND_PRINT: begin
                     mem_we    = 1'b1;
                     mem_waddr = cell_addr(alt_ff, cur_act);
                     mem_wdata = {attr_ff, hb};
                     acur_we   = 1'b1;
                     if (pr_cur == CELLS_C) begin
                        acur_new = LAST_ROW_C;
                        acol_new = '0;
                        wscr_in  = alt_ff;
                        ptr_in   = COLS_C;
                        state_in = S_SCROLL;
                     end else begin
                        acur_new = pr_cur;
                        acol_new = (col_act == COL_MAX) ? '0 : col_act + 1'b1;
                     end
                  end
               endcase
            end
         end
         S_PARSE: begin
            if (walk_ff == esc_cnt_ff) begin
               state_in = S_APPLY;
            end else begin
               walk_in = walk_ff + 1'b1;
               if (walk_ff >= CNT_W'(2) && row_act_ff) begin
                  if (is_digit(walk_b)) row_num_in = dec_step(row_num_ff, walk_b);
                  else row_act_in = 1'b0;
               end
               if (col_act_ff) begin
                  if (is_digit(walk_b)) col_num_in = dec_step(col_num_ff, walk_b);
                  else col_act_in = 1'b0;
               end
               if (!semi_ff && walk_b == CH_SEMI) begin
                  semi_in    = 1'b1;
                  col_act_in = 1'b1;
                  col_num_in = 10'd0;
               end
            end
         end
         S_APPLY: begin
            esc_cnt_in = '0;
            state_in   = S_DONE;
            if (alt_on_hit) begin
               alt_in   = 1'b1;
               wscr_in  = 1'b1;
               ptr_in   = '0;
               end_in   = CELLS_C;
               state_in = S_FILL;
            end else if (alt_off_hit) begin
               alt_in = 1'b0;
            end else if (final_byte_ff == CH_H) begin
               acur_we  = 1'b1;
               acur_new = h_prod[CUR_W-1:0];
               acol_new = col_m1[COL_W-1:0];
            end else if (final_byte_ff == CH_J) begin
               wscr_in  = alt_ff;
               state_in = S_FILL;
               if (row_num_ff == 10'd1) begin
                  ptr_in = '0;
                  end_in = pr_cur;
               end else if (row_num_ff == 10'd2) begin
                  ptr_in = '0;
                  end_in = CELLS_C;
               end else begin
                  ptr_in = cur_act;
                  end_in = CELLS_C;
               end
            end else if (final_byte_ff == CH_K) begin
               wscr_in  = alt_ff;
               state_in = S_FILL;
               if (row_num_ff == 10'd1) begin
                  ptr_in = k_start;
                  end_in = pr_cur;
               end else if (row_num_ff == 10'd2) begin
                  ptr_in = k_start;
                  end_in = k_start + COLS_C;
               end else begin
                  ptr_in = cur_act;
                  end_in = k_start + COLS_C;
               end
            end
         end
         S_SCROLL: begin
            if (pw_valid_ff) begin
               mem_we    = 1'b1;
               mem_waddr = cell_addr(wscr_ff, pw_idx_ff);
               mem_wdata = mem_rdata;
            end
            if (ptr_ff < CELLS_C) begin
               mem_re      = 1'b1;
               mem_raddr   = cell_addr(wscr_ff, ptr_ff);
               ptr_in      = ptr_ff + 1'b1;
               pw_valid_in = 1'b1;
               pw_idx_in   = ptr_ff - COLS_C;
            end else begin
               ptr_in   = LAST_ROW_C;
               end_in   = CELLS_C;
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            if (ptr_ff < end_ff) begin
               mem_we    = 1'b1;
               mem_waddr = cell_addr(wscr_ff, ptr_ff);
               ptr_in    = ptr_ff + 1'b1;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_cell_in  = cell_sel_ff ? mem_rdata : 16'd0;
               rsp_cur_in   = 11'(cur_act);
               rsp_alt_in   = alt_ff;
               rsp_beep_in  = beep_ff;
               rsp_esc_in   = (esc_cnt_ff != '0);
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         attr_ff      <= ATTR_RESET;
         alt_ff       <= 1'b0;
         cur_main_ff  <= '0;
         cur_alt_ff   <= '0;
         col_main_ff  <= '0;
         col_alt_ff   <= '0;
         esc_cnt_ff   <= '0;
         clr_ptr_ff   <= '0;
         pw_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         alt_ff       <= alt_in;
         esc_cnt_ff   <= esc_cnt_in;
         clr_ptr_ff   <= clr_ptr_in;
         pw_valid_ff  <= pw_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_ch.valid) begin
            attr_ff <= csr_ch.text_attribute;
         end
         if (acur_we) begin
            if (alt_ff) begin
               cur_alt_ff <= acur_new;
               col_alt_ff <= acol_new;
            end else begin
               cur_main_ff <= acur_new;
               col_main_ff <= acol_new;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      final_byte_ff <= final_byte_in;
      walk_ff       <= walk_in;
      row_num_ff    <= row_num_in;
      col_num_ff    <= col_num_in;
      row_act_ff    <= row_act_in;
      col_act_ff    <= col_act_in;
      semi_ff       <= semi_in;
      beep_ff       <= beep_in;
      cell_sel_ff   <= cell_sel_in;
      ptr_ff        <= ptr_in;
      end_ff        <= end_in;
      pw_idx_ff     <= pw_idx_in;
      wscr_ff       <= wscr_in;
      rsp_cell_ff   <= rsp_cell_in;
      rsp_cur_ff    <= rsp_cur_in;
      rsp_alt_ff    <= rsp_alt_in;
      rsp_beep_ff   <= rsp_beep_in;
      rsp_esc_ff    <= rsp_esc_in;
      if (st_we) begin
         esc_store_ff[st_idx] <= hb;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.cell_value     = rsp_cell_ff;
   assign rsp_ch.cursor_pos     = rsp_cur_ff;
   assign rsp_ch.alt_active     = rsp_alt_ff;
   assign rsp_ch.beep           = rsp_beep_ff;
   assign rsp_ch.escape_pending = rsp_esc_ff;
endmodule
`default_nettype wire

// File: tb/sv/tb_text_terminal_writer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Text terminal writer testbench
// Sends directed and random terminal bytes and cell reads, tracks both
// screens, the cursors and the escape collector in a local terminal image,
// and checks every response word field by field against that image.
// ----------------------------------------------------------------------------
module tb_text_terminal_writer_top;
   import ttw_pkg::*;

   localparam int COLS        = DEF_COLUMNS;
   localparam int ROWS        = DEF_ROWS;
   localparam int CELLS       = COLS * ROWS;
   localparam int ESC_MAX     = DEF_ESCAPE_LIMIT;
   localparam int STALL_LIMIT = 30000;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASE_WORDS = 540;

   localparam logic [7:0] CH_QMARK = 8'h3F;
   localparam logic [7:0] CH_X     = 8'h78;

   typedef enum bit {CMD_WRITE = 1'b0, CMD_READ = 1'b1} cmd_type;

   typedef struct {
      cmd_type     cmd;
      logic [7:0]  data_byte;
      logic [10:0] read_index;
      logic        read_screen;
   } term_word_type;

   typedef struct {
      logic [15:0] cell_value;
      logic [10:0] cursor_pos;
      logic        alt_active;
      logic        beep;
      logic        escape_pending;
   } term_status_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ttw_req_if req_ch();
   ttw_rsp_if rsp_ch();
   ttw_csr_if csr_ch();

   text_terminal_writer_top dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   term_word_type   send_q[$];
   term_status_type status_q[$];

   logic [15:0] main_img[CELLS];
   logic [15:0] alt_img[CELLS];
   int          main_cur, alt_cur;
   bit          alt_sel;
   logic [7:0]  esc_buf[ESC_MAX];
   int          esc_len;
   logic [7:0]  attr;

   int  errors = 0;
   int  send_idle_pct = 0, recv_idle_pct = 0;
   bit  offering = 1'b0;
   bit  start_hold = 1'b0;
   int  hold_left = 0;
   int  quiet = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // terminal image
   function automatic logic [15:0] blank();
      return {attr, CH_SPACE};
   endfunction

   task automatic fill(input bit scr, input int from, input int upto);
      for (int j = from; j < upto && j < CELLS; j++)
         if (scr) alt_img[j] = blank(); else main_img[j] = blank();
   endtask

   function automatic int esc_number(input int pos);
      int v;
      v = 0;
      while (pos < esc_len && esc_buf[pos] >= CH_ZERO && esc_buf[pos] <= CH_NINE) begin
         v = v * 10 + int'(esc_buf[pos] - CH_ZERO);
         if (v > PARAM_MAX) v = PARAM_MAX;
         pos++;
      end
      return v;
   endfunction

   function automatic int clamp1(input int v, input int hi);
      if (v == 0) return 1;
      return v > hi ? hi : v;
   endfunction

   function automatic bit esc_is(input logic [7:0] seq[ALT_SEQ_LEN]);
      if (esc_len != ALT_SEQ_LEN) return 1'b0;
      for (int i = 0; i < ALT_SEQ_LEN; i++)
         if (esc_buf[i] !== seq[i]) return 1'b0;
      return 1'b1;
   endfunction

   task automatic run_sequence(input logic [7:0] fin, inout int cur);
      int row, col, mode, start;
      if (esc_is(SEQ_ALT_ON)) begin
         alt_sel = 1'b1;
         fill(1'b1, 0, CELLS);
         cur = alt_cur;
      end else if (esc_is(SEQ_ALT_OFF)) begin
         alt_sel = 1'b0;
         cur = main_cur;
      end else if (fin == CH_H) begin
         row = clamp1(esc_number(2), ROWS);
         col = 1;
         for (int i = 0; i < esc_len; i++)
            if (esc_buf[i] == CH_SEMI) begin
               col = esc_number(i + 1);
               break;
            end
         col = clamp1(col, COLS);
         cur = (row - 1) * COLS + (col - 1);
      end else if (fin == CH_J) begin
         mode = esc_number(2);
         if (mode == 1) fill(alt_sel, 0, cur + 1);
         else if (mode == 2) fill(alt_sel, 0, CELLS);
         else fill(alt_sel, cur, CELLS);
      end else if (fin == CH_K) begin
         mode = esc_number(2);
         start = cur - cur % COLS;
         if (mode == 1) fill(alt_sel, start, cur + 1);
         else if (mode == 2) fill(alt_sel, start, start + COLS);
         else fill(alt_sel, cur, start + COLS);
      end
      esc_len = 0;
   endtask

   task automatic apply_word(input term_word_type w, output term_status_type s);
      int cur;
      s = '{default: '0};
      if (w.cmd == CMD_READ) begin
         if (w.read_index < CELLS)
            s.cell_value = w.read_screen ? alt_img[w.read_index] : main_img[w.read_index];
      end else begin
         cur = alt_sel ? alt_cur : main_cur;
         if (esc_len == 0) begin
            if (w.data_byte == CH_BELL) begin
               s.beep = 1'b1;
            end else if (w.data_byte == CH_ESC) begin
               esc_buf[0] = w.data_byte;
               esc_len = 1;
            end else begin
               if (w.data_byte == CH_BS) begin
                  if (cur > 0) begin
                     cur--;
                     if (alt_sel) alt_img[cur] = blank(); else main_img[cur] = blank();
                  end
               end else if (w.data_byte == CH_NL) begin
                  cur += COLS - cur % COLS;
               end else begin
                  if (cur < CELLS) begin
                     if (alt_sel) alt_img[cur] = {attr, w.data_byte};
                     else main_img[cur] = {attr, w.data_byte};
                  end
                  cur++;
               end
               if (cur >= CELLS) begin
                  for (int j = 0; j < CELLS - COLS; j++)
                     if (alt_sel) alt_img[j] = alt_img[j + COLS];
                     else main_img[j] = main_img[j + COLS];
                  fill(alt_sel, CELLS - COLS, CELLS);
                  cur = CELLS - COLS;
               end
            end
         end else begin
            if (esc_len < ESC_MAX) begin
               esc_buf[esc_len] = w.data_byte;
               esc_len++;
            end
            if (w.data_byte >= CH_FINAL_LO && w.data_byte <= CH_FINAL_HI &&
                w.data_byte != CH_LBRACKET)
               run_sequence(w.data_byte, cur);
         end
         if (alt_sel) alt_cur = cur; else main_cur = cur;
      end
      s.cursor_pos     = 11'(alt_sel ? alt_cur : main_cur);
      s.alt_active     = alt_sel;
      s.escape_pending = esc_len != 0;
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid = 1'b0;
      end else if (!offering) begin
         if (send_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_ch.cmd         = send_q[0].cmd;
            req_ch.data_byte   = send_q[0].data_byte;
            req_ch.read_index  = send_q[0].read_index;
            req_ch.read_screen = send_q[0].read_screen;
            req_ch.valid       = 1'b1;
            offering           = 1'b1;
         end else begin
            req_ch.valid = 1'b0;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (start_hold) begin
         hold_left  = HOLD_CYCLES;
         start_hold = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready = 1'b0;
      end else begin
         rsp_ch.ready = $urandom_range(0, 99) >= recv_idle_pct;
      end
   end

   // monitor
   always @(posedge clock) begin
      term_status_type exp_s;
      term_word_type   w;
      if (!reset) begin
         quiet++;
         if (csr_ch.valid && csr_ch.ready) attr = csr_ch.text_attribute;
         if (req_ch.valid && req_ch.ready) begin
            w = send_q.pop_front();
            apply_word(w, exp_s);
            status_q.push_back(exp_s);
            offering = 1'b0;
            quiet = 0;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            quiet = 0;
            if (status_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected response word");
            end else begin
               exp_s = status_q.pop_front();
               if (rsp_ch.cell_value !== exp_s.cell_value ||
                   rsp_ch.cursor_pos !== exp_s.cursor_pos ||
                   rsp_ch.alt_active !== exp_s.alt_active ||
                   rsp_ch.beep !== exp_s.beep ||
                   rsp_ch.escape_pending !== exp_s.escape_pending) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: exp cell=%h cur=%0d alt=%b beep=%b esc=%b, ",
                              exp_s.cell_value, exp_s.cursor_pos, exp_s.alt_active,
                              exp_s.beep, exp_s.escape_pending,
                              "got cell=%h cur=%0d alt=%b beep=%b esc=%b",
                              rsp_ch.cell_value, rsp_ch.cursor_pos, rsp_ch.alt_active,
                              rsp_ch.beep, rsp_ch.escape_pending);
               end
            end
         end
         if (quiet >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // stimulus
   task automatic add_byte(input logic [7:0] b);
      send_q.push_back('{CMD_WRITE, b, 11'($urandom_range(0, 2047)), 1'($urandom_range(0, 1))});
   endtask

   task automatic add_read(input int idx, input bit scr);
      send_q.push_back('{CMD_READ, 8'($urandom_range(0, 255)), 11'(idx), scr});
   endtask

   task automatic add_digits(input int n);
      for (int i = 0; i < n; i++) add_byte(CH_ZERO + 8'($urandom_range(0, 9)));
   endtask

   task automatic add_csi(input logic [7:0] fin);
      add_byte(CH_ESC);
      add_byte(CH_LBRACKET);
      add_digits($urandom_range(0, 4));
      if (fin == CH_H && $urandom_range(0, 3) != 0) begin
         add_byte(CH_SEMI);
         add_digits($urandom_range(0, 4));
      end
      add_byte(fin);
   endtask

   task automatic add_alt(input bit on);
      for (int i = 0; i < ALT_SEQ_LEN; i++) add_byte(on ? SEQ_ALT_ON[i] : SEQ_ALT_OFF[i]);
   endtask

   task automatic add_random(input int n);
      int target, pick;
      target = send_q.size() + n;
      while (send_q.size() < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(32, 126)));
         else if (pick < 40) add_byte(CH_NL);
         else if (pick < 45) add_byte(CH_BS);
         else if (pick < 48) add_byte(CH_BELL);
         else if (pick < 60) add_csi(CH_H);
         else if (pick < 68) add_csi(CH_J);
         else if (pick < 76) add_csi(CH_K);
         else if (pick < 80) add_alt(1'b1);
         else if (pick < 84) add_alt(1'b0);
         else if (pick < 94) add_read($urandom_range(0, 2047), 1'($urandom_range(0, 1)));
         else if (pick < 97) add_byte(8'($urandom_range(0, 255)));
         else begin
            add_byte(CH_ESC);
            repeat ($urandom_range(0, 20))
               add_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 63))
                                             : 8'($urandom_range(128, 255)));
            add_byte(8'($urandom_range(64, 127)));
         end
      end
   endtask

   task automatic drain();
      while (send_q.size() > 0 || status_q.size() > 0 || offering) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_attr(input logic [7:0] v);
      @(negedge clock);
      csr_ch.text_attribute = v;
      csr_ch.valid = 1'b1;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.cmd = CMD_WRITE;
      req_ch.data_byte = '0;
      req_ch.read_index = '0;
      req_ch.read_screen = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.text_attribute = '0;
      for (int j = 0; j < CELLS; j++) begin
         main_img[j] = CELL_RESET;
         alt_img[j] = CELL_RESET;
      end
      main_cur = 0;
      alt_cur = 0;
      alt_sel = 1'b0;
      esc_len = 0;
      attr = ATTR_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 7;
      recv_idle_pct = 56;
      add_read(0, 1'b0);
      add_byte(CH_BS);
      add_byte(CH_BELL);
      add_byte(8'hFF);
      add_byte(8'h00);
      add_byte(CH_NL);
      add_byte(CH_ESC); add_byte(CH_LBRACKET); add_byte(CH_H);
      add_byte(CH_ESC); add_byte(CH_LBRACKET); add_digits(5); add_byte(CH_SEMI);
      add_digits(4); add_byte(CH_H);
      add_byte(CH_ESC); add_byte(CH_LBRACKET); add_byte(CH_ZERO + 8'd1); add_byte(CH_K);
      add_byte(CH_ESC); add_byte(CH_LBRACKET); add_byte(CH_ZERO + 8'd2); add_byte(CH_J);
      add_alt(1'b1);
      add_byte(8'h41);
      add_read(1999, 1'b1);
      add_read(2047, 1'b0);
      add_alt(1'b0);
      add_byte(CH_ESC); add_byte(CH_LBRACKET); add_byte(CH_QMARK); add_byte(CH_X);
      add_byte(CH_ESC); repeat (20) add_byte(8'h80); add_byte(CH_J);
      add_random(PHASE_WORDS);
      wait (req_ch.ready === 1'b1);
      start_hold = 1'b1;
      drain();

      write_attr(8'hFF);
      send_idle_pct = 56;
      recv_idle_pct = 7;
      add_random(PHASE_WORDS);
      drain();

      write_attr(8'($urandom_range(1, 254)));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      add_random(PHASE_WORDS);
      drain();

      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
`default_nettype wire
